// File: design/midi_note_off_tracker_core_macros.svh
// Assertion macros for the note-off tracker core.
// Depends on nothing; included by the top level only.
`ifndef MIDI_NOTE_OFF_TRACKER_CORE_MACROS_SVH
`define MIDI_NOTE_OFF_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define MNOT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define MNOT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mnot_pkg.sv
// Shared types, codes and the control program of the note-off tracker.
// Depends on nothing; used by mnot_table, midi_note_off_tracker_core and the testbench.
package mnot_pkg;

    localparam int TABLE_DEPTH_DEF = 8;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] OP_EFFECT = 2'd0;
    localparam logic [1:0] OP_PASS   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Route codes of a result.
    localparam logic ROUTE_EFFECT = 1'b0;
    localparam logic ROUTE_ONWARD = 1'b1;

    // Table selection codes in the control word.
    localparam logic TSEL_EFFECT = 1'b0;
    localparam logic TSEL_PASS   = 1'b1;

    // One tracked note: channel, match key and the note to restore.
    typedef struct packed {
        logic [3:0] channel;
        logic [6:0] orig;
        logic [6:0] note;
    } entry_t;

    // Write controls of one table.
    typedef struct packed {
        logic wr;
        logic free;
        logic clr;
    } tbl_ctl_t;

    // One result item without its last marker.
    typedef struct packed {
        logic       route;
        logic [3:0] channel;
        logic [6:0] orig;
        logic [6:0] note;
        logic       off;
    } res_t;

    // Micro-operations of the sequencer.
    typedef enum logic [2:0] {
        U_WAIT,
        U_CLEAR,
        U_SCAN_MATCH,
        U_FALLBACK,
        U_SCAN_FREE,
        U_EMIT,
        U_FLUSH
    } uop_t;

    typedef logic [2:0] step_t;

    // Program addresses.
    localparam step_t S_WAIT      = 3'd0;
    localparam step_t S_CLEAR     = 3'd1;
    localparam step_t S_SCAN_PASS = 3'd2;
    localparam step_t S_SCAN_EFF  = 3'd3;
    localparam step_t S_FALLBACK  = 3'd4;
    localparam step_t S_SCAN_FREE = 3'd5;
    localparam step_t S_EMIT      = 3'd6;
    localparam step_t S_FLUSH     = 3'd7;

    localparam int NUM_STEPS = 8;

    // One control word: the operation, the table it works on and the step
    // that follows once the operation completes.
    typedef struct packed {
        uop_t  uop;
        logic  tsel;
        step_t nxt;
    } ucode_t;

    // The control program, indexed by step address.
    localparam ucode_t UCODE [NUM_STEPS] = '{
        '{uop: U_WAIT,       tsel: TSEL_EFFECT, nxt: S_WAIT},
        '{uop: U_CLEAR,      tsel: TSEL_EFFECT, nxt: S_WAIT},
        '{uop: U_SCAN_MATCH, tsel: TSEL_PASS,   nxt: S_SCAN_EFF},
        '{uop: U_SCAN_MATCH, tsel: TSEL_EFFECT, nxt: S_FALLBACK},
        '{uop: U_FALLBACK,   tsel: TSEL_EFFECT, nxt: S_FLUSH},
        '{uop: U_SCAN_FREE,  tsel: TSEL_EFFECT, nxt: S_FLUSH},
        '{uop: U_EMIT,       tsel: TSEL_EFFECT, nxt: S_FLUSH},
        '{uop: U_FLUSH,      tsel: TSEL_EFFECT, nxt: S_WAIT}
    };

endpackage

// File: design/mnot_table.sv
// One note table: valid bits in flip-flops and entries read at the scan index.
// Depends on mnot_pkg for the entry and control types.
module mnot_table #(
    parameter int DEPTH = mnot_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [IDX_W-1:0]   idx,
    input  mnot_pkg::tbl_ctl_t ctl,
    input  mnot_pkg::entry_t   wdata,
    output logic               rd_valid,
    output mnot_pkg::entry_t   rd_entry
);
    import mnot_pkg::*;

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    entry_t           ents_reg [DEPTH];

    // Clear empties every entry; otherwise the scanned entry is filled or freed.
    always_comb begin
        valid_next = valid_reg;
        if (ctl.clr) begin
            valid_next = '0;
        end else if (ctl.wr) begin
            valid_next[idx] = 1'b1;
        end else if (ctl.free) begin
            valid_next[idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload needs no reset: it is only read behind its valid bit.
    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            ents_reg[idx] <= wdata;
        end
    end

    assign rd_valid = valid_reg[idx];
    assign rd_entry = ents_reg[idx];

endmodule

// File: design/midi_note_off_tracker_core.sv
// Top level of the note-off tracker: a microcoded sequencer over two note tables.
// Depends on mnot_pkg, mnot_table and midi_note_off_tracker_core_macros.svh.
//
//  channel   direction  signals                      contents
//  s_        in         s_tvalid s_tready s_tdata    note event (tuser: op, is_off, unknown_len)
//  m_        out        m_tvalid m_tready m_tdata    result note (tuser: route, out_off; tlast)
//  cfg_      in         cfg_valid cfg_ready cfg_data out_enable register
//
// One item is handled at a time; the step counter walks a fixed program.
// A note-off scans the passthrough table and then the effect table, one entry per cycle while the output
// does not stall; a tracked note-on scans its table for a free entry, a known-length note-on is emitted directly.
// Reset clears both tables' valid bits at once and empties the output register.
// Each result waits in a pending register until the next is known, so the last
// marker is exact; a stalled output holds the sequencer on the step that emits.
module midi_note_off_tracker_core #(
    parameter int TABLE_DEPTH = mnot_pkg::TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // channel[3:0], orig_note[10:4], note_number[17:11]
    input  logic [3:0]  s_tuser,   // op[1:0], is_off[2], unknown_len[3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_channel[3:0], out_orig_note[10:4], out_note[17:11]
    output logic [1:0]  m_tuser,   // route[0], out_off[1]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import mnot_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    // Sequencer and datapath registers.
    step_t            upc_reg,        upc_next;
    logic [IDX_W-1:0] idx_reg,        idx_next;
    logic [1:0]       op_reg,         op_next;
    logic [3:0]       ch_reg,         ch_next;
    logic [6:0]       orig_reg,       orig_next;
    logic [6:0]       note_reg,       note_next;
    logic             found_reg,      found_next;
    logic             pend_valid_reg, pend_valid_next;
    res_t             pend_reg,       pend_next;
    logic             m_valid_reg,    m_valid_next;
    res_t             m_res_reg,      m_res_next;
    logic             m_last_reg,     m_last_next;
    logic             out_en_reg,     out_en_next;

    ucode_t   cw;
    logic     tbl_sel;
    logic     rd_valid;
    entry_t   rd_entry;
    logic     pass_rd_valid, eff_rd_valid;
    entry_t   pass_rd_entry, eff_rd_entry;
    tbl_ctl_t pass_ctl, eff_ctl;
    entry_t   wdata;
    logic     match;
    logic     idx_end;
    logic     out_free;
    logic     emit_req;
    res_t     emit_res;
    logic     emit_live;
    logic     stall;

    assign cw = UCODE[upc_reg];

    // Tables, both addressed by the scan index.
    assign wdata = '{channel: ch_reg, orig: orig_reg, note: note_reg};

    mnot_table #(.DEPTH(TABLE_DEPTH)) u_pass (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .idx      (idx_reg),
        .ctl      (pass_ctl),
        .wdata    (wdata),
        .rd_valid (pass_rd_valid),
        .rd_entry (pass_rd_entry)
    );

    mnot_table #(.DEPTH(TABLE_DEPTH)) u_eff (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .idx      (idx_reg),
        .ctl      (eff_ctl),
        .wdata    (wdata),
        .rd_valid (eff_rd_valid),
        .rd_entry (eff_rd_entry)
    );

    // The insert scan picks its table from the op; match scans from the control word.
    assign tbl_sel  = (cw.uop == U_SCAN_FREE) ? op_reg[0] : cw.tsel;
    assign rd_valid = (tbl_sel == TSEL_PASS) ? pass_rd_valid : eff_rd_valid;
    assign rd_entry = (tbl_sel == TSEL_PASS) ? pass_rd_entry : eff_rd_entry;
    assign match    = rd_valid && (rd_entry.channel == ch_reg) && (rd_entry.orig == orig_reg);
    assign idx_end  = (idx_reg == IDX_LAST);
    assign out_free = !m_valid_reg || m_tready;

    // Decode the result that the current step produces, if any.
    always_comb begin
        emit_req = 1'b0;
        emit_res = '{route: op_reg[0], channel: ch_reg, orig: orig_reg,
                     note: note_reg, off: 1'b0};
        unique case (cw.uop)
            U_SCAN_MATCH: begin
                emit_req       = match;
                emit_res.route = (cw.tsel == TSEL_PASS) ? ROUTE_ONWARD : ROUTE_EFFECT;
                emit_res.note  = rd_entry.note;
                emit_res.off   = 1'b1;
            end
            U_FALLBACK: begin
                emit_req       = !found_reg;
                emit_res.route = ROUTE_EFFECT;
                emit_res.off   = 1'b1;
            end
            U_SCAN_FREE: begin
                emit_req = !rd_valid;
            end
            U_EMIT: begin
                emit_req = 1'b1;
            end
            default: begin
                emit_req = 1'b0;
            end
        endcase
    end

    // A result is kept only with outputs enabled; pushing the pending one needs room.
    assign emit_live = emit_req && out_en_reg;
    assign stall = (emit_live && pend_valid_reg && !out_free) ||
                   ((cw.uop == U_FLUSH) && pend_valid_reg && !out_free);

    // Step sequencing, table writes and the result path.
    always_comb begin
        upc_next        = upc_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        ch_next         = ch_reg;
        orig_next       = orig_reg;
        note_next       = note_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_res_next      = m_res_reg;
        m_last_next     = m_last_reg;
        out_en_next     = out_en_reg;
        pass_ctl        = '0;
        eff_ctl         = '0;

        if (cfg_valid) begin
            out_en_next = cfg_data;
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (!stall) begin
            // A new result displaces the pending one, which cannot be the last.
            if (emit_live) begin
                if (pend_valid_reg) begin
                    m_valid_next = 1'b1;
                    m_res_next   = pend_reg;
                    m_last_next  = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_next       = emit_res;
            end

            unique case (cw.uop)
                U_WAIT: begin
                    if (s_tvalid) begin
                        op_next    = s_tuser[1:0];
                        ch_next    = s_tdata[3:0];
                        orig_next  = s_tdata[10:4];
                        note_next  = s_tdata[17:11];
                        found_next = 1'b0;
                        idx_next   = '0;
                        if (s_tuser[1:0] == OP_NONE) begin
                            upc_next = S_WAIT;
                        end else if (s_tuser[1:0] == OP_CLEAR) begin
                            upc_next = S_CLEAR;
                        end else if (s_tuser[2]) begin
                            upc_next = S_SCAN_PASS;
                        end else if (s_tuser[3]) begin
                            upc_next = S_SCAN_FREE;
                        end else begin
                            upc_next = S_EMIT;
                        end
                    end
                end
                U_CLEAR: begin
                    pass_ctl.clr = 1'b1;
                    eff_ctl.clr  = 1'b1;
                    upc_next     = cw.nxt;
                end
                U_SCAN_MATCH: begin
                    if (match) begin
                        note_next = rd_entry.note;
                        if (cw.tsel == TSEL_PASS) begin
                            pass_ctl.free = 1'b1;
                        end else begin
                            eff_ctl.free = 1'b1;
                            found_next   = 1'b1;
                        end
                    end
                    if (idx_end) begin
                        idx_next = '0;
                        upc_next = cw.nxt;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                U_SCAN_FREE: begin
                    if (!rd_valid) begin
                        if (op_reg[0] == TSEL_PASS) begin
                            pass_ctl.wr = 1'b1;
                        end else begin
                            eff_ctl.wr = 1'b1;
                        end
                        idx_next = '0;
                        upc_next = cw.nxt;
                    end else if (idx_end) begin
                        idx_next = '0;
                        upc_next = cw.nxt;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                U_FALLBACK, U_EMIT: begin
                    upc_next = cw.nxt;
                end
                U_FLUSH: begin
                    if (pend_valid_reg) begin
                        m_valid_next    = 1'b1;
                        m_res_next      = pend_reg;
                        m_last_next     = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    upc_next = cw.nxt;
                end
                default: begin
                    upc_next = S_WAIT;
                end
            endcase
        end
    end

    // Control state is reset; payload registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg        <= S_WAIT;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            out_en_reg     <= 1'b0;
        end else begin
            upc_reg        <= upc_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            out_en_reg     <= out_en_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        ch_reg     <= ch_next;
        orig_reg   <= orig_next;
        note_reg   <= note_next;
        pend_reg   <= pend_next;
        m_res_reg  <= m_res_next;
        m_last_reg <= m_last_next;
    end

    // Port drive.
    assign s_tready  = (cw.uop == U_WAIT);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'b0, m_res_reg.note, m_res_reg.orig, m_res_reg.channel};
    assign m_tuser   = {m_res_reg.off, m_res_reg.route};
    assign m_tlast   = m_last_reg;

    // Checks on the sequencer.
    `include "midi_note_off_tracker_core_macros.svh"

    `MNOT_ASSERT_NOW(a_idle_no_pending, aclk, aresetn, s_tready, !pend_valid_reg, "pending result held while taking a new item")
    `MNOT_ASSERT_NEXT(a_flush_marks_last, aclk, aresetn, (cw.uop == U_FLUSH) && pend_valid_reg && out_free, m_valid_reg && m_last_reg, "flush did not present a last result")
    `MNOT_ASSERT_NOW(a_idx_in_range, aclk, aresetn, 1'b1, idx_reg <= IDX_LAST, "scan index beyond table depth")

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the note-off tracker core over its streaming ports.
// Depends on mnot_pkg and midi_note_off_tracker_core; predicts every result from
// its own copy of both note tables and compares each result as it arrives.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mnot_pkg::*;

    localparam int TBL_DEPTH     = TABLE_DEPTH_DEF;
    // Cycles to let a scan finish when no result marks its end.
    localparam int SETTLE_CYCLES = 2 * (2 * TBL_DEPTH + 3);
    localparam int IDLE_PERCENT  = 30;

    // One input event, as carried on s_tdata and s_tuser.
    typedef struct {
        logic [1:0] op;
        logic [3:0] channel;
        logic [6:0] orig;
        logic [6:0] note;
        logic       off;
        logic       unk;
    } note_event_t;

    // One result note, as carried on m_tdata, m_tuser and m_tlast.
    typedef struct {
        logic       route;
        logic [3:0] channel;
        logic [6:0] orig;
        logic [6:0] note;
        logic       off;
        logic       last;
    } note_result_t;

    // One tracked note in the predictor's tables.
    typedef struct {
        bit         used;
        logic [3:0] channel;
        logic [6:0] orig;
        logic [6:0] note;
    } tracked_note_t;

    typedef struct {
        logic [3:0] channel;
        logic [6:0] orig;
    } note_key_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // channel[3:0], orig_note[10:4], note_number[17:11]
    logic [3:0]  s_tuser;   // op[1:0], is_off[2], unknown_len[3]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // out_channel[3:0], out_orig_note[10:4], out_note[17:11]
    logic [1:0]  m_tuser;   // route[0], out_off[1]
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    // Predictor state: both tables, indexed by table select code, and the register.
    tracked_note_t note_tables [2][TBL_DEPTH];
    bit            out_enable_model;
    note_result_t  expected_notes [$];
    note_key_t     live_keys [$];

    bit no_idle;
    int error_count;
    int events_sent;
    int results_checked;
    int cfg_writes;

    midi_note_off_tracker_core #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard limit on the run time.
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // The result side stalls at random unless a no-idle stretch is running.
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    function automatic note_event_t make_event(logic [1:0] op, logic [3:0] channel,
                                               logic [6:0] orig, logic [6:0] note,
                                               logic off, logic unk);
        note_event_t ev;
        ev.op      = op;
        ev.channel = channel;
        ev.orig    = orig;
        ev.note    = note;
        ev.off     = off;
        ev.unk     = unk;
        return ev;
    endfunction

    // Updates the predictor's tables for one accepted event and queues its results.
    task automatic track_note_event(input note_event_t ev);
        note_result_t burst [$];
        note_result_t r;
        logic [6:0]   running;
        bit           matched;
        bit           stored;
        int           tsel;
        running = ev.note;
        matched = 1'b0;
        stored  = 1'b0;
        r.channel = ev.channel;
        r.orig    = ev.orig;
        r.off     = ev.off;
        r.last    = 1'b0;
        if (ev.op == OP_NONE)
            return;
        if (ev.op == OP_CLEAR) begin
            for (int i = 0; i < TBL_DEPTH; i++) begin
                note_tables[TSEL_EFFECT][i].used = 1'b0;
                note_tables[TSEL_PASS][i].used   = 1'b0;
            end
            return;
        end
        if (ev.off) begin
            // Passthrough matches first; each one also becomes the running note.
            for (int i = 0; i < TBL_DEPTH; i++) begin
                if (note_tables[TSEL_PASS][i].used &&
                    note_tables[TSEL_PASS][i].channel == ev.channel &&
                    note_tables[TSEL_PASS][i].orig == ev.orig) begin
                    running = note_tables[TSEL_PASS][i].note;
                    r.route = ROUTE_ONWARD;
                    r.note  = running;
                    burst.push_back(r);
                    note_tables[TSEL_PASS][i].used = 1'b0;
                end
            end
            for (int i = 0; i < TBL_DEPTH; i++) begin
                if (note_tables[TSEL_EFFECT][i].used &&
                    note_tables[TSEL_EFFECT][i].channel == ev.channel &&
                    note_tables[TSEL_EFFECT][i].orig == ev.orig) begin
                    running = note_tables[TSEL_EFFECT][i].note;
                    r.route = ROUTE_EFFECT;
                    r.note  = running;
                    burst.push_back(r);
                    note_tables[TSEL_EFFECT][i].used = 1'b0;
                    matched = 1'b1;
                end
            end
            // Nothing in the effect table: the effect still gets a note-off.
            if (!matched) begin
                r.route = ROUTE_EFFECT;
                r.note  = running;
                burst.push_back(r);
            end
        end else begin
            r.route = (ev.op == OP_PASS) ? ROUTE_ONWARD : ROUTE_EFFECT;
            r.note  = ev.note;
            if (ev.unk) begin
                // Tracked note-on: first free entry, dropped when the table is full.
                tsel = (ev.op == OP_PASS) ? TSEL_PASS : TSEL_EFFECT;
                for (int i = 0; i < TBL_DEPTH; i++) begin
                    if (!stored && !note_tables[tsel][i].used) begin
                        note_tables[tsel][i].used    = 1'b1;
                        note_tables[tsel][i].channel = ev.channel;
                        note_tables[tsel][i].orig    = ev.orig;
                        note_tables[tsel][i].note    = ev.note;
                        stored = 1'b1;
                    end
                end
                if (stored)
                    burst.push_back(r);
            end else begin
                burst.push_back(r);
            end
        end
        if (!out_enable_model || burst.size() == 0)
            return;
        burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            expected_notes.push_back(burst[i]);
    endtask

    // Offers one event and waits for its transfer; may then leave a gap.
    task automatic send_event(input note_event_t ev);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, ev.note, ev.orig, ev.channel};
        s_tuser  <= {ev.unk, ev.off, ev.op};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        track_note_event(ev);
        events_sent++;
        if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge aclk);
        end
    endtask

    // Waits until every expected result has arrived and the block has gone quiet.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (expected_notes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES)
            @(posedge aclk);
    endtask

    task automatic write_out_enable(input bit value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        out_enable_model = value;
        cfg_writes++;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Every result transfer is compared with the oldest expected one.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_notes.size() == 0) begin
                report_mismatch("unexpected result, data", m_tdata, 0);
            end else begin
                if (m_tuser[0] !== expected_notes[0].route)
                    report_mismatch("route", m_tuser[0], expected_notes[0].route);
                if (m_tdata[3:0] !== expected_notes[0].channel)
                    report_mismatch("out_channel", m_tdata[3:0], expected_notes[0].channel);
                if (m_tdata[10:4] !== expected_notes[0].orig)
                    report_mismatch("out_orig_note", m_tdata[10:4], expected_notes[0].orig);
                if (m_tdata[17:11] !== expected_notes[0].note)
                    report_mismatch("out_note", m_tdata[17:11], expected_notes[0].note);
                if (m_tuser[1] !== expected_notes[0].off)
                    report_mismatch("out_off", m_tuser[1], expected_notes[0].off);
                if (m_tlast !== expected_notes[0].last)
                    report_mismatch("last", m_tlast, expected_notes[0].last);
                void'(expected_notes.pop_front());
                results_checked++;
            end
        end
    end

    // Known-length note-ons at the field extremes, one per route.
    task automatic test_known_length();
        send_event(make_event(OP_EFFECT, 4'd0, 7'd0, 7'd0, 1'b0, 1'b0));
        send_event(make_event(OP_PASS, 4'd15, 7'd127, 7'd127, 1'b0, 1'b0));
        settle_block();
    endtask

    // A note-off releases the passthrough entry before the effect entry.
    task automatic test_match_order();
        send_event(make_event(OP_PASS, 4'd15, 7'd127, 7'd5, 1'b0, 1'b1));
        send_event(make_event(OP_EFFECT, 4'd15, 7'd127, 7'd9, 1'b0, 1'b1));
        send_event(make_event(OP_EFFECT, 4'd15, 7'd127, 7'd100, 1'b1, 1'b1));
        settle_block();
    endtask

    // Unmatched note-offs fall back to the effect with the running note.
    task automatic test_running_note();
        send_event(make_event(OP_EFFECT, 4'd3, 7'd64, 7'd77, 1'b1, 1'b0));
        send_event(make_event(OP_PASS, 4'd3, 7'd10, 7'd20, 1'b0, 1'b1));
        send_event(make_event(OP_PASS, 4'd3, 7'd10, 7'd99, 1'b1, 1'b0));
        settle_block();
    endtask

    // Nine equal keys into an eight-entry table: the last is dropped and the
    // note-off then releases all eight duplicates.
    task automatic test_table_full();
        for (int i = 0; i <= TBL_DEPTH; i++)
            send_event(make_event(OP_EFFECT, 4'd7, 7'd40, 7'(i), 1'b0, 1'b1));
        send_event(make_event(OP_EFFECT, 4'd7, 7'd40, 7'd1, 1'b1, 1'b1));
        settle_block();
    endtask

    // Clear empties the tables; the undefined op does nothing at all.
    task automatic test_clear_and_undefined();
        send_event(make_event(OP_PASS, 4'd12, 7'd90, 7'd30, 1'b0, 1'b1));
        send_event(make_event(OP_CLEAR, 4'd12, 7'd90, 7'd30, 1'b1, 1'b1));
        send_event(make_event(OP_NONE, 4'd12, 7'd90, 7'd31, 1'b1, 1'b0));
        send_event(make_event(OP_PASS, 4'd12, 7'd90, 7'd66, 1'b1, 1'b0));
        settle_block();
    endtask

    // With outputs disabled the tables still fill; the entry shows up afterwards.
    task automatic test_outputs_disabled();
        write_out_enable(1'b0);
        send_event(make_event(OP_PASS, 4'd9, 7'd33, 7'd44, 1'b0, 1'b1));
        send_event(make_event(OP_EFFECT, 4'd9, 7'd34, 7'd45, 1'b0, 1'b0));
        settle_block();
        write_out_enable(1'b1);
        send_event(make_event(OP_EFFECT, 4'd9, 7'd33, 7'd0, 1'b1, 1'b0));
        settle_block();
    endtask

    // Mostly note-on and note-off pairs over a pool of live keys, with some noise.
    task automatic random_event(output note_event_t ev);
        note_key_t key;
        int        pick;
        int        idx;
        ev.op      = 2'($urandom_range(0, 1));
        ev.channel = 4'($urandom_range(0, 15));
        ev.orig    = 7'($urandom_range(0, 127));
        ev.note    = 7'($urandom_range(0, 127));
        ev.unk     = 1'($urandom_range(0, 1));
        ev.off     = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 40 && live_keys.size() > 14)
            pick = 50;
        if (pick < 40) begin
            // Tracked note-on, sometimes reusing a live key to make duplicates.
            if (live_keys.size() != 0 && $urandom_range(0, 99) < 30) begin
                key = live_keys[$urandom_range(0, live_keys.size() - 1)];
                ev.channel = key.channel;
                ev.orig    = key.orig;
            end
            ev.unk = 1'b1;
            key.channel = ev.channel;
            key.orig    = ev.orig;
            live_keys.push_back(key);
        end else if (pick < 75) begin
            ev.off = 1'b1;
            if (live_keys.size() != 0 && $urandom_range(0, 99) < 85) begin
                idx = $urandom_range(0, live_keys.size() - 1);
                ev.channel = live_keys[idx].channel;
                ev.orig    = live_keys[idx].orig;
                live_keys.delete(idx);
            end
        end else if (pick < 85) begin
            ev.unk = 1'b0;
        end else if (pick < 90) begin
            ev.off = 1'b1;
        end else if (pick < 94) begin
            ev.op  = OP_CLEAR;
            ev.off = 1'($urandom_range(0, 1));
            live_keys.delete();
        end else if (pick < 97) begin
            ev.op  = OP_NONE;
            ev.off = 1'($urandom_range(0, 1));
        end else begin
            ev.op  = 2'($urandom_range(0, 3));
            ev.off = 1'($urandom_range(0, 1));
            if (ev.op == OP_CLEAR)
                live_keys.delete();
        end
    endtask

    task automatic run_random_phase(input bit enable, input bit steady, input int count);
        note_event_t ev;
        write_out_enable(enable);
        no_idle = steady;
        for (int i = 0; i < count; i++) begin
            random_event(ev);
            send_event(ev);
        end
        settle_block();
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(1'b1, 1'b1, 80);
        run_random_phase(1'b1, 1'b0, 180);
        run_random_phase(1'b0, 1'b0, 60);
        run_random_phase(1'b1, 1'b0, 150);
    endtask

    // Reset, directed tests, random traffic, then the verdict.
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        no_idle   = 1'b0;
        error_count      = 0;
        events_sent      = 0;
        results_checked  = 0;
        cfg_writes       = 0;
        out_enable_model = 1'b0;
        foreach (note_tables[t, i])
            note_tables[t][i].used = 1'b0;
        repeat (9)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_out_enable(1'b1);
        test_known_length();
        test_match_order();
        test_running_note();
        test_table_full();
        test_clear_and_undefined();
        test_outputs_disabled();
        test_random_traffic();

        $display("Sent %0d note events and checked %0d results over %0d register writes,",
                 events_sent, results_checked, cfg_writes);
        $display("including full tables, duplicate keys, clears and disabled outputs.");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/mnot_pkg.sv
design/mnot_table.sv
design/midi_note_off_tracker_core.sv
tb/sv/tb.sv
